/* rtl/blom_pairwise_key_share_core_defines.svh */
// Assertion macros shared by the key share core.
`ifndef BLOM_PAIRWISE_KEY_SHARE_CORE_DEFINES_SVH
`define BLOM_PAIRWISE_KEY_SHARE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BPK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BPK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/blom_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package blom_pkg;

   localparam int TABLE_LEN    = 5;
   localparam int COEFF_COUNT  = 5;
   localparam int SLOT_W       = 3;
   localparam int COEFF_W      = 16;
   localparam int CSR_ADDR_W   = 3;
   localparam int FIELD_W      = 17;

   localparam logic [SLOT_W-1:0] UNKNOWN_SLOT = 3'd3;
   localparam logic [FIELD_W-1:0] FIELD_P     = 17'h10001;

   localparam logic [7:0] SLOT_BYTES [TABLE_LEN] = '{8'h3B, 8'h1A, 8'hC6, 8'h5D, 8'h00};

   typedef logic [2:0] pc_type;

   localparam pc_type PC_FETCH  = 3'd0;
   localparam pc_type PC_LOOKUP = 3'd1;
   localparam pc_type PC_MUL    = 3'd2;
   localparam pc_type PC_ACC    = 3'd3;
   localparam pc_type PC_EMIT   = 3'd4;

   typedef enum logic [2:0] {
      OP_FETCH,
      OP_LOOKUP,
      OP_MUL,
      OP_ACC,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      JC_NONE,
      JC_HIT,
      JC_MORE,
      JC_ALWAYS
   } jcond_type;

   typedef struct packed {
      op_type    op;
      jcond_type jc;
      pc_type    target;
   } ucode_type;

   // Control store: one word per step of the sequencer.
   function automatic ucode_type ucode_at(input pc_type pc);
      ucode_type uw;
      unique case (pc)
         PC_FETCH:  uw = '{op: OP_FETCH,  jc: JC_NONE,   target: PC_LOOKUP};
         PC_LOOKUP: uw = '{op: OP_LOOKUP, jc: JC_HIT,    target: PC_EMIT};
         PC_MUL:    uw = '{op: OP_MUL,    jc: JC_NONE,   target: PC_ACC};
         PC_ACC:    uw = '{op: OP_ACC,    jc: JC_MORE,   target: PC_MUL};
         PC_EMIT:   uw = '{op: OP_EMIT,   jc: JC_ALWAYS, target: PC_FETCH};
         default:   uw = '{op: OP_FETCH,  jc: JC_ALWAYS, target: PC_FETCH};
      endcase
      return uw;
   endfunction

   // Reduction modulo 65537: lo - hi, plus 65537 when that goes negative.
   function automatic logic [FIELD_W-1:0] fold_mod(input logic [31:0] v);
      logic [FIELD_W-1:0] lo;
      logic [FIELD_W-1:0] hi;
      logic [FIELD_W-1:0] diff;
      lo   = {1'b0, v[15:0]};
      hi   = {1'b0, v[31:16]};
      diff = lo - hi;
      if (v[15:0] < v[31:16]) begin
         diff = diff + FIELD_P;
      end
      return diff;
   endfunction

endpackage

`default_nettype wire

/* rtl/blom_pairwise_key_share_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "blom_pairwise_key_share_core_defines.svh"

// Channel   Direction  Payload
// req_      in         tdata[7:0] peer_addr_byte
// rsp_      out        tdata[15:0] secret, tdata[18:16] peer_slot; tuser fresh
// csr_      in         addr 0..4 selects coeff_0..coeff_4, wdata[15:0]
//
// rsp_tvalid rises once a taken word has passed the lookup and emit steps if
// its secret is cached; for a fresh secret the lookup is followed by one
// multiply and one fold-and-accumulate step per coefficient after the first,
// then emit. One input word is worked on at a time; the result register lets
// the next word be taken while a result still waits. Reset clears the secret
// cache and the coefficients.

module blom_pairwise_key_share_core #(
   parameter int NUM_SLOTS = 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,   // [7:0] peer_addr_byte
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [23:0]                             rsp_tdata,   // [15:0] secret, [18:16] peer_slot
   output logic                                    rsp_tuser,   // [0] fresh
   input  wire logic                               csr_we,
   input  wire logic [blom_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [blom_pkg::COEFF_W-1:0]       csr_wdata
);

   import blom_pkg::*;

   pc_type                 pc_ff, pc_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic                   fresh_ff, fresh_in;
   logic [FIELD_W-1:0]     sum_ff, sum_in;
   logic [FIELD_W-1:0]     pw_ff, pw_in;
   logic [19:0]            pw2_ff, pw2_in;
   logic [31:0]            prod_ff, prod_in;
   logic [COEFF_W-1:0]     coeff_ff [COEFF_COUNT];
   logic [COEFF_W-1:0]     cache_ff [TABLE_LEN];
   logic [COEFF_W-1:0]     cache_in [TABLE_LEN];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [18:0]            rsp_data_ff, rsp_data_in;
   logic                   rsp_fresh_ff, rsp_fresh_in;

   ucode_type              uw;
   logic                   advance;
   logic                   taken;
   logic                   hit;
   logic                   more;
   logic                   emit_go;
   logic [SLOT_W-1:0]      match_slot;
   logic [COEFF_W-1:0]     cache_rd;
   logic [31:0]            mul_full;
   logic [FIELD_W-1:0]     prod_red;
   logic [FIELD_W:0]       acc_sum;
   logic [SLOT_W-1:0]      idx_nxt;

   // Lowest matching table position wins; only the first NUM_SLOTS bytes count.
   always_comb begin
      match_slot = UNKNOWN_SLOT;
      for (int i = TABLE_LEN - 1; i >= 0; i--) begin
         if (i < NUM_SLOTS && req_tdata == SLOT_BYTES[i]) begin
            match_slot = SLOT_W'(i);
         end
      end
   end

   assign uw       = ucode_at(pc_ff);
   assign cache_rd = cache_ff[slot_ff];
   assign hit      = (cache_rd != '0);
   // The product of a 16-bit coefficient and a reduced power always fits 32 bits.
   assign mul_full = {16'd0, coeff_ff[idx_ff]} * {15'd0, pw_ff};
   assign prod_red = fold_mod(prod_ff);
   assign acc_sum  = {1'b0, sum_ff} + {1'b0, prod_red};
   assign idx_nxt  = idx_ff + 3'd1;
   assign more     = (idx_nxt < SLOT_W'(NUM_SLOTS));

   always_comb begin
      pc_in        = pc_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      fresh_in     = fresh_ff;
      sum_in       = sum_ff;
      pw_in        = pw_ff;
      pw2_in       = pw2_ff;
      prod_in      = prod_ff;
      cache_in     = cache_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_fresh_in = rsp_fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      advance      = 1'b1;
      emit_go      = 1'b0;

      unique case (uw.op)
         OP_FETCH: begin
            advance = req_tvalid;
            if (req_tvalid) begin
               slot_in = match_slot;
            end
         end
         OP_LOOKUP: begin
            fresh_in = !hit;
            sum_in   = hit ? {1'b0, cache_rd} : {1'b0, coeff_ff[0]};
            pw_in    = {14'd0, slot_ff};
            idx_in   = 3'd1;
         end
         OP_MUL: begin
            prod_in = mul_full;
            pw2_in  = {3'd0, pw_ff} * {17'd0, slot_ff};
         end
         OP_ACC: begin
            sum_in = fold_mod({14'd0, acc_sum});
            pw_in  = fold_mod({12'd0, pw2_ff});
            idx_in = idx_nxt;
         end
         OP_EMIT: begin
            advance = !rsp_valid_ff || rsp_tready;
            emit_go = advance;
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {slot_ff, sum_ff[15:0]};
               rsp_fresh_in = fresh_ff;
               if (fresh_ff) begin
                  cache_in[slot_ff] = sum_ff[15:0];
               end
            end
         end
         default: advance = 1'b1;
      endcase

      unique case (uw.jc)
         JC_NONE:   taken = 1'b0;
         JC_HIT:    taken = hit;
         JC_MORE:   taken = more;
         JC_ALWAYS: taken = 1'b1;
         default:   taken = 1'b0;
      endcase

      if (advance) begin
         pc_in = taken ? uw.target : pc_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_FETCH;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_LEN; i++) begin
            cache_ff[i] <= '0;
         end
         for (int i = 0; i < COEFF_COUNT; i++) begin
            coeff_ff[i] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         cache_ff     <= cache_in;
         if (csr_we && csr_addr < CSR_ADDR_W'(COEFF_COUNT)) begin
            coeff_ff[csr_addr] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      idx_ff       <= idx_in;
      fresh_ff     <= fresh_in;
      sum_ff       <= sum_in;
      pw_ff        <= pw_in;
      pw2_ff       <= pw2_in;
      prod_ff      <= prod_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_fresh_ff <= rsp_fresh_in;
   end

   assign req_tready = (uw.op == OP_FETCH);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};
   assign rsp_tuser  = rsp_fresh_ff;

   // A secret served from the cache is never zero, since zero marks an empty entry.
   `BPK_ASSERT_NOW(a_cached_nonzero, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata[15:0] != 16'd0, "cached secret is zero")

   // A freshly computed secret lands in the cache entry of its slot.
   `BPK_ASSERT_NEXT(a_cache_written, clock, reset, emit_go && fresh_ff,
      cache_ff[slot_ff] == rsp_data_ff[15:0], "fresh secret not cached")

   // The coefficient index never runs past the configured slot count.
   `BPK_ASSERT_NOW(a_idx_range, clock, reset, uw.op == OP_MUL,
      idx_ff < SLOT_W'(NUM_SLOTS), "coefficient index out of range")

endmodule

`default_nettype wire
